// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/core/aapr_pkg.sv =====
package aapr_pkg;
	localparam int CordicStages = 24;
	localparam int NumStages = CordicStages + 7;

	localparam logic signed [33:0] AngPi = 34'sd843314857;
	localparam logic signed [33:0] AngHalfPi = 34'sd421657428;
	localparam logic signed [33:0] AngTwoPi = 34'sd1686629713;
	localparam logic signed [33:0] CordicK = 34'sd652032874;
	localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [31:0] turn_angle;
		logic forward;
	} aapr_in_t;

	typedef struct packed {
		logic signed [31:0] rotated_x;
		logic signed [31:0] rotated_y;
		logic signed [31:0] rotated_z;
		logic saturated;
	} aapr_out_t;

	function automatic logic signed [33:0] atan_entry(input int i);
		logic signed [33:0] r;
		case (i)
			0: r = 34'sd210828714;
			1: r = 34'sd124459457;
			2: r = 34'sd65760959;
			3: r = 34'sd33381290;
			4: r = 34'sd16755422;
			5: r = 34'sd8385879;
			6: r = 34'sd4193963;
			7: r = 34'sd2097109;
			8: r = 34'sd1048571;
			9: r = 34'sd524287;
			default: r = (i < 29) ? (34'sd1 <<< (28 - i)) : 34'sd0;
		endcase
		return r;
	endfunction
endpackage

// ===== rtl/core/axis_angle_point_rotate_core.sv =====
// Pipeline: stage 1, the quadrant fold, the CORDIC iterations, then stages 2 to 6.
// Throughput: one transaction per cycle; the whole pipeline advances when the
// output register is empty or being taken, so a stall holds every stage.
// Reset: arst_n clears all stage valid bits and snap_threshold to zero.
`include "assert_macros.svh"
module axis_angle_point_rotate_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  aapr_pkg::aapr_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output aapr_pkg::aapr_out_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data
);
	import aapr_pkg::*;

	localparam int NS = CordicStages;

	logic [15:0] snap_threshold_q;
	logic adv;

	// One enable for the whole pipeline: it moves when the output slot frees.
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_threshold_q <= '0;
		end else if (cfg_valid) begin
			snap_threshold_q <= cfg_data;
		end
	end

	// Stage 1: negate the angle when not forward, clamp the axis and bring the angle into [-pi, pi].
	logic v_s1;
	logic signed [33:0] ang_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic signed [15:0] ax_s1, ay_s1, az_s1;

	function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] a);
		if (a > 16'sd16384) return 16'sd16384;
		if (a < -16'sd16384) return -16'sd16384;
		return a;
	endfunction

	logic signed [33:0] ang_in, ang_red;
	always_comb begin
		ang_in = in_data.forward ? 34'(in_data.turn_angle) : -34'(in_data.turn_angle);
		if (ang_in > AngPi) ang_red = ang_in - AngTwoPi;
		else if (ang_in < -AngPi) ang_red = ang_in + AngTwoPi;
		else ang_red = ang_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1 <= ang_red;
			px_s1 <= in_data.point_x;
			py_s1 <= in_data.point_y;
			pz_s1 <= in_data.point_z;
			ax_s1 <= clamp_axis(in_data.axis_x);
			ay_s1 <= clamp_axis(in_data.axis_y);
			az_s1 <= clamp_axis(in_data.axis_z);
		end
	end

	// CORDIC pipeline: entry 0 is the quadrant fold, entry i+1 follows iteration i.
	logic cv [NS+1];
	logic cneg [NS+1];
	logic signed [33:0] cx [NS+1];
	logic signed [33:0] cy [NS+1];
	logic signed [33:0] cz [NS+1];
	logic signed [31:0] cpx [NS+1], cpy [NS+1], cpz [NS+1];
	logic signed [15:0] cax [NS+1], cay [NS+1], caz [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv[0] <= 1'b0;
		end else if (adv) begin
			cv[0] <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cx[0] <= CordicK;
			cy[0] <= '0;
			if (ang_s1 > AngHalfPi) begin
				cz[0] <= ang_s1 - AngPi;
				cneg[0] <= 1'b1;
			end else if (ang_s1 < -AngHalfPi) begin
				cz[0] <= ang_s1 + AngPi;
				cneg[0] <= 1'b1;
			end else begin
				cz[0] <= ang_s1;
				cneg[0] <= 1'b0;
			end
			cpx[0] <= px_s1; cpy[0] <= py_s1; cpz[0] <= pz_s1;
			cax[0] <= ax_s1; cay[0] <= ay_s1; caz[0] <= az_s1;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		localparam logic signed [33:0] Atan = atan_entry(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv[i+1] <= 1'b0;
			end else if (adv) begin
				cv[i+1] <= cv[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cz[i][33]) begin
					cx[i+1] <= cx[i] - (cy[i] >>> i);
					cy[i+1] <= cy[i] + (cx[i] >>> i);
					cz[i+1] <= cz[i] - Atan;
				end else begin
					cx[i+1] <= cx[i] + (cy[i] >>> i);
					cy[i+1] <= cy[i] - (cx[i] >>> i);
					cz[i+1] <= cz[i] + Atan;
				end
				cneg[i+1] <= cneg[i];
				cpx[i+1] <= cpx[i]; cpy[i+1] <= cpy[i]; cpz[i+1] <= cpz[i];
				cax[i+1] <= cax[i]; cay[i+1] <= cay[i]; caz[i+1] <= caz[i];
			end
		end
	end

	// Stage 2: final sign fix, t = 1 - c, cq, and the axis products a*b.
	logic v_s2;
	logic signed [33:0] s_s2, t_s2, cq_s2;
	logic signed [31:0] px_s2, py_s2, pz_s2;
	logic signed [15:0] ax_s2, ay_s2, az_s2;
	logic signed [31:0] pxx_s2, pxy_s2, pxz_s2, pyy_s2, pyz_s2, pzz_s2;
	logic signed [33:0] c_fin, s_fin;
	logic signed [33:0] c_rnd;

	always_comb begin
		c_fin = cneg[NS] ? -cx[NS] : cx[NS];
		s_fin = cneg[NS] ? -cy[NS] : cy[NS];
		c_rnd = (c_fin + 34'sd2) >>> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= cv[NS];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2 <= s_fin;
			t_s2 <= OneQ30 - c_fin;
			cq_s2 <= c_rnd;
			px_s2 <= cpx[NS]; py_s2 <= cpy[NS]; pz_s2 <= cpz[NS];
			ax_s2 <= cax[NS]; ay_s2 <= cay[NS]; az_s2 <= caz[NS];
			pxx_s2 <= 32'(cax[NS]) * 32'(cax[NS]);
			pxy_s2 <= 32'(cax[NS]) * 32'(cay[NS]);
			pxz_s2 <= 32'(cax[NS]) * 32'(caz[NS]);
			pyy_s2 <= 32'(cay[NS]) * 32'(cay[NS]);
			pyz_s2 <= 32'(cay[NS]) * 32'(caz[NS]);
			pzz_s2 <= 32'(caz[NS]) * 32'(caz[NS]);
		end
	end

	// Stage 3: t*ab and s*a products, rounded to Q28.
	logic v_s3;
	logic signed [33:0] cq_s3;
	logic signed [31:0] px_s3, py_s3, pz_s3;
	logic signed [33:0] txx_s3, txy_s3, txz_s3, tyy_s3, tyz_s3, tzz_s3;
	logic signed [33:0] sx_s3, sy_s3, sz_s3;

	function automatic logic signed [33:0] tprod(input logic signed [33:0] t,
			input logic signed [31:0] ab);
		logic signed [65:0] p;
		p = 66'(t) * 66'(ab) + (66'sd1 <<< 29);
		return 34'(p >>> 30);
	endfunction

	function automatic logic signed [33:0] sprod(input logic signed [33:0] s,
			input logic signed [15:0] a);
		logic signed [49:0] p;
		p = 50'(s) * 50'(a) + 50'sd32768;
		return 34'(p >>> 16);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cq_s3 <= cq_s2;
			px_s3 <= px_s2; py_s3 <= py_s2; pz_s3 <= pz_s2;
			txx_s3 <= tprod(t_s2, pxx_s2);
			txy_s3 <= tprod(t_s2, pxy_s2);
			txz_s3 <= tprod(t_s2, pxz_s2);
			tyy_s3 <= tprod(t_s2, pyy_s2);
			tyz_s3 <= tprod(t_s2, pyz_s2);
			tzz_s3 <= tprod(t_s2, pzz_s2);
			sx_s3 <= sprod(s_s2, ax_s2);
			sy_s3 <= sprod(s_s2, ay_s2);
			sz_s3 <= sprod(s_s2, az_s2);
		end
	end

	// Stage 4: matrix entries.
	logic v_s4;
	logic signed [31:0] px_s4, py_s4, pz_s4;
	logic signed [34:0] m_s4 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4 <= px_s3; py_s4 <= py_s3; pz_s4 <= pz_s3;
			m_s4[0][0] <= 35'(cq_s3) + 35'(txx_s3);
			m_s4[0][1] <= 35'(txy_s3) + 35'(sz_s3);
			m_s4[0][2] <= 35'(txz_s3) - 35'(sy_s3);
			m_s4[1][0] <= 35'(txy_s3) - 35'(sz_s3);
			m_s4[1][1] <= 35'(cq_s3) + 35'(tyy_s3);
			m_s4[1][2] <= 35'(tyz_s3) + 35'(sx_s3);
			m_s4[2][0] <= 35'(txz_s3) + 35'(sy_s3);
			m_s4[2][1] <= 35'(tyz_s3) - 35'(sx_s3);
			m_s4[2][2] <= 35'(cq_s3) + 35'(tzz_s3);
		end
	end

	// Stage 5: the nine entry-by-coordinate products.
	logic v_s5;
	logic signed [66:0] prod_s5 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end
	for (genvar r = 0; r < 3; r++) begin : g_prod
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s5[r][0] <= 67'(m_s4[r][0]) * 67'(px_s4);
				prod_s5[r][1] <= 67'(m_s4[r][1]) * 67'(py_s4);
				prod_s5[r][2] <= 67'(m_s4[r][2]) * 67'(pz_s4);
			end
		end
	end

	// Stage 6: row sums, rounding to Q16.16, snap and saturate into the output register.
	function automatic logic signed [39:0] round_row(input logic signed [66:0] a,
			input logic signed [66:0] b, input logic signed [66:0] c);
		logic signed [68:0] s;
		s = 69'(a) + 69'(b) + 69'(c) + (69'sd1 <<< 27);
		return 40'(s >>> 28);
	endfunction

	logic signed [39:0] row [3];
	logic signed [39:0] mag [3];
	logic signed [31:0] res [3];
	logic [2:0] clip;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row[r] = round_row(prod_s5[r][0], prod_s5[r][1], prod_s5[r][2]);
			mag[r] = row[r][39] ? -row[r] : row[r];
			clip[r] = 1'b0;
			if (mag[r] < 40'(snap_threshold_q)) begin
				res[r] = '0;
			end else if (row[r] > 40'sd2147483647) begin
				res[r] = 32'sh7fffffff;
				clip[r] = 1'b1;
			end else if (row[r] < -40'sd2147483648) begin
				res[r] = 32'sh80000000;
				clip[r] = 1'b1;
			end else begin
				res[r] = row[r][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.rotated_x <= res[0];
			out_data.rotated_y <= res[1];
			out_data.rotated_z <= res[2];
			out_data.saturated <= |clip;
		end
	end

	// A stalled output must hold its transaction until taken.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "output changed while stalled")
	// The pipeline only refuses input while a result waits.
	`ASSERT_IMPL(a_ready_rule, clk, arst_n, in_ready == (!out_valid || out_ready),
		"input ready does not follow the output slot")
	// A saturated result holds at least one component at a rail.
	`ASSERT_IMPL(a_sat_rail, clk, arst_n, !(out_valid && out_data.saturated) ||
		out_data.rotated_x == 32'sh7fffffff || out_data.rotated_x == 32'sh80000000 ||
		out_data.rotated_y == 32'sh7fffffff || out_data.rotated_y == 32'sh80000000 ||
		out_data.rotated_z == 32'sh7fffffff || out_data.rotated_z == 32'sh80000000,
		"saturated flag without a clipped component")
endmodule

// ===== verif/axis_angle_point_rotate_core_test.sv =====
module axis_angle_point_rotate_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import aapr_pkg::*;

	// Cycles without any transaction before the run is declared hung. The
	// longest legal quiet stretch is the receiver hold-off plus the pipeline
	// latency, far below this.
	localparam int StallLimit = 4000;
	localparam int HoldCycles = 400;
	localparam int PhaseItems = 460;

	// Keeps the predicted rotations in order and compares each result
	// against the oldest one. The predictor is a bit-exact fixed-point
	// Rodrigues rotation with a CORDIC for sine and cosine.
	class rotation_scoreboard;
		aapr_out_t expected_q[$];
		int unsigned mismatches;
		int unsigned results_seen;
		logic [15:0] snap_level;

		function new();
			mismatches = 0;
			results_seen = 0;
			snap_level = '0;
		endfunction

		static function longint round_shift(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		static function longint clamp_axis(longint a);
			if (a > 16384) return 16384;
			if (a < -16384) return -16384;
			return a;
		endfunction

		static function longint arctan(int i);
			longint tab[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
				8385879, 4193963, 2097109, 1048571, 524287};
			if (i < 10) return tab[i];
			if (i < 29) return longint'(1) <<< (28 - i);
			return 0;
		endfunction

		// Sine and cosine in Q30 of a Q28 angle, after folding into the
		// range the CORDIC converges on.
		static function void sine_cosine(longint a, output longint cs, output longint sn);
			longint x, y, z, dx, dy;
			bit flip;
			flip = 1'b0;
			if (a > longint'(AngPi)) a -= longint'(AngTwoPi);
			else if (a < -longint'(AngPi)) a += longint'(AngTwoPi);
			if (a > longint'(AngHalfPi)) begin
				a -= longint'(AngPi);
				flip = 1'b1;
			end else if (a < -longint'(AngHalfPi)) begin
				a += longint'(AngPi);
				flip = 1'b1;
			end
			x = longint'(CordicK);
			y = 0;
			z = a;
			for (int i = 0; i < CordicStages && i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= arctan(i);
				end else begin
					x += dx;
					y -= dy;
					z += arctan(i);
				end
			end
			cs = flip ? -x : x;
			sn = flip ? -y : y;
		endfunction

		function longint finish_row(longint acc, ref bit sat);
			longint r, mag;
			r = (acc + (longint'(1) <<< 27)) >>> 28;
			mag = (r < 0) ? -r : r;
			if (mag < longint'(snap_level)) r = 0;
			if (r > 64'sd2147483647) begin
				r = 64'sd2147483647;
				sat = 1'b1;
			end
			if (r < -64'sd2147483648) begin
				r = -64'sd2147483648;
				sat = 1'b1;
			end
			return r;
		endfunction

		function aapr_out_t rotate(aapr_in_t d);
			longint p[3], ax[3], m[3][3];
			longint ang, c, s, t, cq, acc;
			longint r[3];
			bit sat;
			aapr_out_t o;
			sat = 1'b0;
			p[0] = longint'(d.point_x);
			p[1] = longint'(d.point_y);
			p[2] = longint'(d.point_z);
			ax[0] = clamp_axis(longint'(d.axis_x));
			ax[1] = clamp_axis(longint'(d.axis_y));
			ax[2] = clamp_axis(longint'(d.axis_z));
			ang = longint'(d.turn_angle);
			if (!d.forward) ang = -ang;
			sine_cosine(ang, c, s);
			t = longint'(OneQ30) - c;
			cq = round_shift(c, 2);
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					m[i][j] = round_shift(t * (ax[i] * ax[j]), 30);
			// Cross-product terms carry the sign pattern of the matrix.
			m[0][0] += cq;
			m[1][1] += cq;
			m[2][2] += cq;
			m[0][1] += round_shift(s * ax[2], 16);
			m[0][2] -= round_shift(s * ax[1], 16);
			m[1][0] -= round_shift(s * ax[2], 16);
			m[1][2] += round_shift(s * ax[0], 16);
			m[2][0] += round_shift(s * ax[1], 16);
			m[2][1] -= round_shift(s * ax[0], 16);
			for (int k = 0; k < 3; k++) begin
				acc = m[k][0] * p[0] + m[k][1] * p[1] + m[k][2] * p[2];
				r[k] = finish_row(acc, sat);
			end
			o.rotated_x = r[0][31:0];
			o.rotated_y = r[1][31:0];
			o.rotated_z = r[2][31:0];
			o.saturated = sat;
			return o;
		endfunction

		function void note_input(aapr_in_t d);
			expected_q.push_back(rotate(d));
		endfunction

		function void check_result(aapr_out_t got);
			aapr_out_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %h", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.rotated_x !== want.rotated_x || got.rotated_y !== want.rotated_y ||
					got.rotated_z !== want.rotated_z || got.saturated !== want.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d want %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
						results_seen, want.rotated_x, want.rotated_y, want.rotated_z,
						want.saturated, got.rotated_x, got.rotated_y, got.rotated_z,
						got.saturated);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	aapr_in_t in_data;
	logic out_valid;
	logic out_ready;
	aapr_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;

	rotation_scoreboard rotations = new();
	int unsigned idle_cycles;
	bit hold_done;

	axis_angle_point_rotate_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Every result transaction goes straight to the scoreboard. Values are
	// read at the edge, before any register update of that edge lands.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			rotations.check_result(out_data);
	end

	// Hang detection: any transaction on any channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("ERROR: no transaction for %0d cycles", StallLimit);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver back-pressure. The pattern switches at random between
	// always ready, a coin toss and mostly stalled. Once, a few hundred
	// results in, the receiver holds off long enough for the pipeline to
	// fill and push back on the sender.
	initial begin
		int mode;
		out_ready <= 1'b0;
		hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 2);
			for (int i = 0; i < 64; i++) begin
				if (!hold_done && rotations.results_seen >= 300) begin
					hold_done = 1'b1;
					out_ready <= 1'b0;
					repeat (HoldCycles) @(posedge clk);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Offers one point and holds it until the block takes it. Valid is left
	// high so that a following point goes out back to back.
	task automatic send_point(aapr_in_t d);
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
		rotations.note_input(d);
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// The register may only change with the pipeline empty: wait for the
	// last expected result, then for the full pipeline depth.
	task automatic set_snap_level(logic [15:0] level);
		in_valid <= 1'b0;
		@(posedge clk);
		while (rotations.expected_q.size() != 0) @(posedge clk);
		repeat (NumStages + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= level;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rotations.snap_level = level;
	endtask

	function automatic aapr_in_t make_point(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic signed [31:0] ang, logic fwd);
		aapr_in_t d;
		d.point_x = px;
		d.point_y = py;
		d.point_z = pz;
		d.axis_x = ax;
		d.axis_y = ay;
		d.axis_z = az;
		d.turn_angle = ang;
		d.forward = fwd;
		return d;
	endfunction

	function automatic logic signed [15:0] random_axis();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 16'($signed($urandom_range(0, 32768)) - 16384);
		if (pick < 85) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		// Anything the 16-bit field can carry, clamped by the block.
		return 16'($urandom);
	endfunction

	function automatic logic signed [31:0] random_coord();
		if ($urandom_range(0, 1)) return 32'($signed($urandom_range(0, 2097152)) - 1048576);
		return 32'($urandom);
	endfunction

	function automatic aapr_in_t random_point();
		aapr_in_t d;
		d.point_x = random_coord();
		d.point_y = random_coord();
		d.point_z = random_coord();
		d.axis_x = random_axis();
		d.axis_y = random_axis();
		d.axis_z = random_axis();
		// Mostly angles within one turn, sometimes the whole field range.
		// The offset wraps modulo 2^32, which gives the signed angle.
		if ($urandom_range(0, 3) == 0) d.turn_angle = 32'($urandom);
		else d.turn_angle = 32'($urandom_range(0, 32'd3373259426) - 32'd1686629713);
		d.forward = 1'($urandom_range(0, 1));
		return d;
	endfunction

	task automatic random_phase(int count);
		int sent, burst;
		bit gapless;
		sent = 0;
		while (sent < count) begin
			gapless = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_point(random_point());
				sent++;
			end
			if (!gapless) pause_sender($urandom_range(1, 8));
		end
	endtask

	initial begin
		localparam logic signed [31:0] Max = 32'sh7fffffff;
		localparam logic signed [31:0] Min = 32'sh80000000;
		localparam logic signed [31:0] One = 32'sh00010000;
		localparam logic signed [15:0] U = 16'sd16384;
		localparam logic signed [31:0] Pi = 32'sd843314857;
		localparam logic signed [31:0] HalfPi = 32'sd421657428;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of the point, each axis direction, angles
		// around the fold points of the CORDIC, and the odd cases.
		set_snap_level(16'd0);
		send_point(make_point(0, 0, 0, U, 0, 0, 0, 1));
		send_point(make_point(One, One, One, U, 0, 0, HalfPi, 1));
		send_point(make_point(One, One, One, 0, U, 0, HalfPi, 0));
		send_point(make_point(One, -One, One, 0, 0, U, Pi, 1));
		send_point(make_point(One, One, -One, -U, 0, 0, -Pi, 1));
		send_point(make_point(One, 2 * One, 3 * One, 0, -U, 0, HalfPi + 1, 1));
		send_point(make_point(One, 2 * One, 3 * One, 0, 0, -U, -HalfPi - 1, 1));
		send_point(make_point(Max, Max, Max, 0, 0, U, Pi, 1));
		send_point(make_point(Min, Min, Min, 0, 0, U, Pi, 1));
		send_point(make_point(Min, Max, Min, 0, 0, U, 0, 1));
		send_point(make_point(Max, Min, Max, 9459, 9459, 9459, HalfPi, 1));
		send_point(make_point(One, One, One, 0, 0, U, Max, 1));
		send_point(make_point(One, One, One, 0, 0, U, Min, 1));
		// Negating the most negative angle must not wrap.
		send_point(make_point(One, One, One, 0, 0, U, Min, 0));
		send_point(make_point(One, One, One, 0, 0, U, Max, 0));
		// Axis components outside the unit range are clamped.
		send_point(make_point(One, One, One, 16'sh8000, 16'sd32767, 0, HalfPi, 1));
		send_point(make_point(One, One, One, 16'sd20000, -16'sd20000, 16'sd32767, Pi, 0));
		// A short, non-unit axis is used as it is.
		send_point(make_point(One, One, One, 16'sd100, 16'sd200, -16'sd300, HalfPi, 1));
		send_point(make_point(-32'sd1, 32'sd1, 32'sd1, 0, 0, 0, 12345, 1));
		send_point(make_point(Max, 0, 0, U, U, U, Pi / 3, 1));
		send_point(make_point(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
			16'sh2aaa, -16'sh1555, 16'sh1f0f, 32'sh5a5a5a5a, 0));

		// Random phases across the range of the snap threshold.
		set_snap_level(16'd65535);
		random_phase(PhaseItems);
		set_snap_level(16'($urandom_range(1, 65534)));
		random_phase(PhaseItems);
		set_snap_level(16'd1);
		random_phase(PhaseItems);
		set_snap_level(16'd0);
		random_phase(PhaseItems);

		in_valid <= 1'b0;
		@(posedge clk);
		while (rotations.expected_q.size() != 0) @(posedge clk);
		repeat (NumStages + 10) @(posedge clk);
		if (rotations.mismatches == 0 && rotations.expected_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("ERROR: %0d mismatches, %0d results missing", rotations.mismatches,
				rotations.expected_q.size());
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
